### hw/rtl/mdtc_pkg.sv
// Shared types and constants for the mouse delta to text cell block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package mdtc_pkg;

  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned BTN_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned MAX_CELLS  = 256;

  localparam int unsigned MICKEY_X_W = 11;
  localparam int unsigned MICKEY_Y_W = 12;
  localparam int unsigned DIV_X      = 6;
  localparam int unsigned DIV_Y      = 14;
  // reciprocals: floor(a / d) == (a * RECIP) >> SH over the unclamped range
  localparam int unsigned RECIP_X    = 43691;
  localparam int unsigned RECIP_X_SH = 18;
  localparam int unsigned RECIP_Y    = 74899;
  localparam int unsigned RECIP_Y_SH = 20;

  localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(80);
  localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(25);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_COLUMNS = 1'b0,
    CFG_SCREEN_ROWS    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                      has_packet;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic [BTN_W-1:0]          buttons;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [BTN_W-1:0]  button_mask;
    logic              moved;
  } out_item_t;

endpackage

### hw/rtl/mdtc_if.sv
// Valid/ready channel interfaces for the input packets and the cell results.
// Depends on mdtc_pkg for field widths.
`timescale 1ns / 1ps

interface mdtc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               has_packet;
  logic signed [mdtc_pkg::DELTA_W-1:0] delta_x;
  logic signed [mdtc_pkg::DELTA_W-1:0] delta_y;
  logic                               left_pressed;
  logic                               right_pressed;
  logic                               middle_pressed;

  modport source (output valid, has_packet, delta_x, delta_y, left_pressed, right_pressed,
                  middle_pressed, input ready);
  modport sink (input valid, has_packet, delta_x, delta_y, left_pressed, right_pressed,
                middle_pressed, output ready);
endinterface

interface mdtc_out_if;
  logic                        valid;
  logic                        ready;
  logic [mdtc_pkg::CELL_W-1:0] cell_x;
  logic [mdtc_pkg::CELL_W-1:0] cell_y;
  logic [mdtc_pkg::BTN_W-1:0]  button_mask;
  logic                        moved;

  modport source (output valid, cell_x, cell_y, button_mask, moved, input ready);
  modport sink (input valid, cell_x, cell_y, button_mask, moved, output ready);
endinterface

### hw/rtl/mdtc_axis.sv
// One cursor axis: mickey accumulator, clamp at zero, divide to a cell, limit to screen.
// Depends on mdtc_pkg.
`timescale 1ns / 1ps

module mdtc_axis #(
  parameter int unsigned ACC_W    = mdtc_pkg::MICKEY_X_W,
  parameter int unsigned DIV      = mdtc_pkg::DIV_X,
  parameter int unsigned RECIP    = mdtc_pkg::RECIP_X,
  parameter int unsigned RECIP_SH = mdtc_pkg::RECIP_X_SH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               update_i,
  input  logic signed [mdtc_pkg::DELTA_W:0]   delta_i,
  input  logic [mdtc_pkg::SIZE_W-1:0]         size_i,
  output logic [mdtc_pkg::CELL_W-1:0]         cell_d_o,
  output logic                               moved_o
);

  localparam int unsigned SUM_W   = mdtc_pkg::DELTA_W + 2;
  localparam int unsigned MAG_W   = SUM_W - 1;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned PROD_W  = ACC_W + RECIP_W;
  localparam int unsigned SIZE_W  = mdtc_pkg::SIZE_W;
  localparam int unsigned CELL_W  = mdtc_pkg::CELL_W;

  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [CELL_W-1:0]       pos_q;
  logic signed [SUM_W-1:0] sum;
  logic [MAG_W-1:0]        mag;
  logic [SIZE_W-1:0]       lim;
  logic [MAG_W-1:0]        limit;
  logic                    over;
  logic [PROD_W-1:0]       prod;
  logic [CELL_W-1:0]       cell_div;
  logic [CELL_W-1:0]       cell_nxt;

  assign sum = SUM_W'($signed({1'b0, acc_q})) + SUM_W'(delta_i);
  assign mag = sum[SUM_W-1] ? '0 : sum[MAG_W-1:0];

  always_comb begin
    if (size_i == '0) begin
      lim = SIZE_W'(1);
    end else if (size_i > SIZE_W'(mdtc_pkg::MAX_CELLS)) begin
      lim = SIZE_W'(mdtc_pkg::MAX_CELLS);
    end else begin
      lim = size_i;
    end
  end

  assign limit    = MAG_W'(lim) * MAG_W'(DIV);
  assign over     = (mag >= limit);
  assign prod     = PROD_W'(mag[ACC_W-1:0]) * PROD_W'(RECIP);
  assign cell_div = prod[RECIP_SH +: CELL_W];

  always_comb begin
    if (over) begin
      cell_nxt = CELL_W'(lim - SIZE_W'(1));
      acc_d    = ACC_W'(limit - MAG_W'(DIV));
    end else begin
      cell_nxt = cell_div;
      acc_d    = mag[ACC_W-1:0];
    end
  end

  assign cell_d_o = update_i ? cell_nxt : pos_q;
  assign moved_o  = update_i && (cell_nxt != pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else if (update_i) begin
      acc_q <= acc_d;
      pos_q <= cell_nxt;
    end
  end

endmodule

### hw/rtl/mouse_delta_to_text_cell_core.sv
// Mouse delta to text cell: accumulates relative packets into a text cursor cell.
// Pipeline: an accepted item is held in the s1 register, then its result is registered into the output register.
// Throughput: one item per cycle while the output is not stalled; the axis update is combinational on the accumulators.
// Reset: accumulators, cell, buttons cleared; screen size 80 columns by 25 rows.
// Depends on mdtc_pkg, mdtc_if and mdtc_axis.
`timescale 1ns / 1ps

module mouse_delta_to_text_cell_core #(
  parameter int unsigned MICKEY_X_W = mdtc_pkg::MICKEY_X_W,
  parameter int unsigned MICKEY_Y_W = mdtc_pkg::MICKEY_Y_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mdtc_in_if.sink                         in_i,
  mdtc_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [mdtc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mdtc_pkg::SIZE_W-1:0]     cfg_wdata_i
);

  logic [mdtc_pkg::SIZE_W-1:0] cols_q, rows_q;
  logic [mdtc_pkg::BTN_W-1:0]  buttons_q;
  logic                        s1_valid_q, s1_valid_d;
  mdtc_pkg::in_item_t          s1_item_q;
  logic                        out_valid_q, out_valid_d;
  mdtc_pkg::out_item_t         out_item_q, out_item_d;
  logic                        out_free, s1_adv, in_acc, update;
  logic [mdtc_pkg::CELL_W-1:0] cell_x_d, cell_y_d;
  logic                        moved_x, moved_y;
  logic signed [mdtc_pkg::DELTA_W:0] dx_ext, dy_neg;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign update     = s1_adv && s1_item_q.has_packet;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  assign dx_ext = (mdtc_pkg::DELTA_W + 1)'(s1_item_q.delta_x);
  assign dy_neg = -((mdtc_pkg::DELTA_W + 1)'(s1_item_q.delta_y));

  mdtc_axis #(
    .ACC_W    (MICKEY_X_W),
    .DIV      (mdtc_pkg::DIV_X),
    .RECIP    (mdtc_pkg::RECIP_X),
    .RECIP_SH (mdtc_pkg::RECIP_X_SH)
  ) u_axis_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (update),
    .delta_i  (dx_ext),
    .size_i   (cols_q),
    .cell_d_o (cell_x_d),
    .moved_o  (moved_x)
  );

  mdtc_axis #(
    .ACC_W    (MICKEY_Y_W),
    .DIV      (mdtc_pkg::DIV_Y),
    .RECIP    (mdtc_pkg::RECIP_Y),
    .RECIP_SH (mdtc_pkg::RECIP_Y_SH)
  ) u_axis_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (update),
    .delta_i  (dy_neg),
    .size_i   (rows_q),
    .cell_d_o (cell_y_d),
    .moved_o  (moved_y)
  );

  always_comb begin
    out_item_d.cell_x      = cell_x_d;
    out_item_d.cell_y      = cell_y_d;
    out_item_d.button_mask = update ? s1_item_q.buttons : buttons_q;
    out_item_d.moved       = moved_x || moved_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= mdtc_pkg::COLS_RESET;
      rows_q      <= mdtc_pkg::ROWS_RESET;
      buttons_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (update) begin
        buttons_q <= s1_item_q.buttons;
      end
      if (cfg_we_i) begin
        case (mdtc_pkg::cfg_idx_e'(cfg_idx_i))
          mdtc_pkg::CFG_SCREEN_COLUMNS: cols_q <= cfg_wdata_i;
          mdtc_pkg::CFG_SCREEN_ROWS:    rows_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q.has_packet <= in_i.has_packet;
      s1_item_q.delta_x    <= in_i.delta_x;
      s1_item_q.delta_y    <= in_i.delta_y;
      s1_item_q.buttons    <= {in_i.middle_pressed, in_i.right_pressed, in_i.left_pressed};
    end
    if (s1_adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.cell_x      = out_item_q.cell_x;
  assign out_o.cell_y      = out_item_q.cell_y;
  assign out_o.button_mask = out_item_q.button_mask;
  assign out_o.moved       = out_item_q.moved;

endmodule
